// ===== rtl/core/stop_and_wait_arq_fsm_core_assert.svh =====
// assertion macros used by the sawa checker file
`ifndef STOP_AND_WAIT_ARQ_FSM_CORE_ASSERT_SVH
`define STOP_AND_WAIT_ARQ_FSM_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SAWA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sawa: implication check failed");

// a stalled transaction keeps its payload into the next cycle
`define SAWA_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig) \
    label: assert property (@(posedge clk) disable iff (!rst_n) ((vld) && !(rdy)) |=> \
        ((vld) && $stable(sig))) else $error("sawa: stalled payload changed");

`endif

// ===== rtl/core/sawa_pkg.sv =====
`timescale 1ns / 1ps

package sawa_pkg;

    // defaults
    localparam int QUEUE_DEPTH = 2;
    localparam logic [7:0] DEST_ID_RST  = 8'd12;
    localparam logic [3:0] MAX_RETX_RST = 4'd3;

    // configuration register indexes
    localparam logic CFG_DEST_ID  = 1'b0;
    localparam logic CFG_MAX_RETX = 1'b1;

    // input commands
    localparam logic [2:0] CMD_DATA_RCVD  = 3'd0;
    localparam logic [2:0] CMD_ACK_RCVD   = 3'd1;
    localparam logic [2:0] CMD_TX_CONFIRM = 3'd2;
    localparam logic [2:0] CMD_TIMEOUT    = 3'd3;
    localparam logic [2:0] CMD_NEW_DATA   = 3'd4;

    // pending event flag positions
    localparam int NUM_EVENTS   = 6;
    localparam int EV_DATA_RCVD = 0;
    localparam int EV_DATA_SEND = 1;
    localparam int EV_DATA_TXD  = 2;
    localparam int EV_ACK_TXD   = 3;
    localparam int EV_ACK_RCVD  = 4;
    localparam int EV_TIMEOUT   = 5;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_TX   = 2'd1,
        ST_WAIT = 2'd2
    } t_fsm_state;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_SEND_DATA = 3'd1,
        ACT_SEND_ACK  = 3'd2,
        ACT_GIVE_UP   = 3'd3,
        ACT_ACK_OK    = 3'd4,
        ACT_DISCARD   = 3'd5
    } t_action;

    typedef enum logic {
        ENG_IDLE = 1'b0,
        ENG_RUN  = 1'b1
    } t_eng_state;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] src_id;
        logic [7:0] frame_seq;
    } t_item;

    typedef struct packed {
        logic [7:0] dest_id;
        logic [3:0] max_retx;
    } t_cfg;

    typedef struct packed {
        t_action    action;
        logic [7:0] tx_seq;
        logic [7:0] tx_dest;
        logic       start_timer;
        logic       stop_timer;
        t_fsm_state machine_state;
        logic       last;
    } t_result;

endpackage

// ===== rtl/core/sawa_front.sv =====
`timescale 1ns / 1ps

module sawa_front #(
    parameter int DEPTH = sawa_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sawa_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output sawa_pkg::t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    sawa_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic known;
    logic push;
    logic pop;

    // classify: commands outside the known set change nothing and are dropped here
    always_comb begin
        unique case (i_item.command) inside
            sawa_pkg::CMD_DATA_RCVD, sawa_pkg::CMD_ACK_RCVD, sawa_pkg::CMD_TX_CONFIRM,
            sawa_pkg::CMD_TIMEOUT, sawa_pkg::CMD_NEW_DATA: known = 1'b1;
            default: known = 1'b0;
        endcase
    end

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready && known;
    assign pop     = o_valid && i_ready;

    // queue pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/sawa_back.sv =====
`timescale 1ns / 1ps

module sawa_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  sawa_pkg::t_item   i_item,
    input  sawa_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output sawa_pkg::t_result o_result
);

    localparam int NE = sawa_pkg::NUM_EVENTS;

    sawa_pkg::t_eng_state r_eng, n_eng;
    sawa_pkg::t_fsm_state r_fsm, n_fsm;
    logic [NE-1:0] r_flags, n_flags;
    logic [7:0]    r_next_seq, n_next_seq;
    logic [7:0]    r_out_seq, n_out_seq;
    logic [3:0]    r_retry, n_retry;
    logic          r_timer, n_timer;
    logic          r_last_ack, n_last_ack;
    logic [7:0]    r_peer_addr, n_peer_addr;
    logic [7:0]    r_peer_seq, n_peer_seq;
    logic          r_have_held, n_have_held;
    sawa_pkg::t_result r_held, n_held;
    logic          r_out_valid, n_out_valid;
    sawa_pkg::t_result r_out, n_out;

    // one protocol pass computed from the current state
    logic              p_take;
    sawa_pkg::t_fsm_state p_fsm;
    logic [NE-1:0]     p_flags;
    logic [7:0]        p_next_seq;
    logic [7:0]        p_out_seq;
    logic [3:0]        p_retry;
    logic              p_timer;
    logic              p_last_ack;
    sawa_pkg::t_result p_res;
    logic              out_free;

    // protocol pass: consume the highest priority flag for the current state
    always_comb begin
        p_take     = 1'b0;
        p_fsm      = r_fsm;
        p_flags    = r_flags;
        p_next_seq = r_next_seq;
        p_out_seq  = r_out_seq;
        p_retry    = r_retry;
        p_timer    = r_timer;
        p_last_ack = r_last_ack;
        p_res      = '0;
        p_res.action = sawa_pkg::ACT_NONE;
        unique case (r_fsm)
            sawa_pkg::ST_IDLE: begin
                if (r_flags[sawa_pkg::EV_DATA_RCVD]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_DATA_RCVD] = 1'b0;
                    p_res.action = sawa_pkg::ACT_DISCARD;
                end else if (r_flags[sawa_pkg::EV_DATA_SEND]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_DATA_SEND] = 1'b0;
                    p_out_seq  = r_next_seq;
                    p_next_seq = r_next_seq + 8'd1;
                    p_retry    = '0;
                    p_last_ack = 1'b0;
                    p_fsm      = sawa_pkg::ST_TX;
                    p_res.action  = sawa_pkg::ACT_SEND_DATA;
                    p_res.tx_seq  = r_next_seq;
                    p_res.tx_dest = i_cfg.dest_id;
                end else if (r_flags[sawa_pkg::EV_DATA_TXD]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_DATA_TXD] = 1'b0;
                    p_res.action = sawa_pkg::ACT_DISCARD;
                end else if (r_flags[sawa_pkg::EV_ACK_TXD]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_ACK_TXD] = 1'b0;
                    p_res.action = sawa_pkg::ACT_DISCARD;
                end else if (r_flags[sawa_pkg::EV_ACK_RCVD]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_ACK_RCVD] = 1'b0;
                    p_res.action = sawa_pkg::ACT_DISCARD;
                end else if (r_flags[sawa_pkg::EV_TIMEOUT]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_TIMEOUT] = 1'b0;
                    p_res.action = sawa_pkg::ACT_DISCARD;
                end
            end
            sawa_pkg::ST_TX: begin
                if (r_flags[sawa_pkg::EV_DATA_TXD]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_DATA_TXD] = 1'b0;
                    p_timer = 1'b1;
                    p_fsm   = sawa_pkg::ST_WAIT;
                    p_res.start_timer = 1'b1;
                end else if (r_flags[sawa_pkg::EV_ACK_TXD]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_ACK_TXD] = 1'b0;
                    // back to waiting only if a data frame is still in flight
                    p_fsm = (r_timer || r_flags[sawa_pkg::EV_TIMEOUT]) ?
                            sawa_pkg::ST_WAIT : sawa_pkg::ST_IDLE;
                end
            end
            sawa_pkg::ST_WAIT: begin
                if (r_flags[sawa_pkg::EV_ACK_RCVD]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_ACK_RCVD] = 1'b0;
                    p_timer = 1'b0;
                    p_fsm   = sawa_pkg::ST_IDLE;
                    p_res.action     = sawa_pkg::ACT_ACK_OK;
                    p_res.stop_timer = 1'b1;
                end else if (r_flags[sawa_pkg::EV_TIMEOUT]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_TIMEOUT] = 1'b0;
                    if (r_retry < i_cfg.max_retx) begin
                        p_retry    = r_retry + 4'd1;
                        p_last_ack = 1'b0;
                        p_fsm      = sawa_pkg::ST_TX;
                        p_res.action  = sawa_pkg::ACT_SEND_DATA;
                        p_res.tx_seq  = r_out_seq;
                        p_res.tx_dest = i_cfg.dest_id;
                    end else begin
                        p_fsm = sawa_pkg::ST_IDLE;
                        p_res.action = sawa_pkg::ACT_GIVE_UP;
                    end
                end else if (r_flags[sawa_pkg::EV_DATA_RCVD]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_DATA_RCVD] = 1'b0;
                    p_last_ack = 1'b1;
                    p_fsm      = sawa_pkg::ST_TX;
                    p_res.action  = sawa_pkg::ACT_SEND_ACK;
                    p_res.tx_seq  = r_peer_seq;
                    p_res.tx_dest = r_peer_addr;
                end else if (r_flags[sawa_pkg::EV_DATA_TXD]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_DATA_TXD] = 1'b0;
                    p_res.action = sawa_pkg::ACT_DISCARD;
                end else if (r_flags[sawa_pkg::EV_ACK_TXD]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_ACK_TXD] = 1'b0;
                    p_res.action = sawa_pkg::ACT_DISCARD;
                end else if (r_flags[sawa_pkg::EV_DATA_SEND]) begin
                    p_take = 1'b1;
                    p_flags[sawa_pkg::EV_DATA_SEND] = 1'b0;
                    p_res.action = sawa_pkg::ACT_DISCARD;
                end
            end
            default: begin
                p_fsm = sawa_pkg::ST_IDLE;
            end
        endcase
        p_res.machine_state = p_fsm;
    end

    assign o_ready  = (r_eng == sawa_pkg::ENG_IDLE);
    assign out_free = !r_out_valid || i_ready;

    // engine: latch one event, then run passes; a result is held until the next pass shows whether it is last
    always_comb begin
        n_eng       = r_eng;
        n_fsm       = r_fsm;
        n_flags     = r_flags;
        n_next_seq  = r_next_seq;
        n_out_seq   = r_out_seq;
        n_retry     = r_retry;
        n_timer     = r_timer;
        n_last_ack  = r_last_ack;
        n_peer_addr = r_peer_addr;
        n_peer_seq  = r_peer_seq;
        n_have_held = r_have_held;
        n_held      = r_held;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        unique case (r_eng)
            sawa_pkg::ENG_IDLE: begin
                if (i_valid) begin
                    n_eng       = sawa_pkg::ENG_RUN;
                    n_have_held = 1'b0;
                    unique case (i_item.command)
                        sawa_pkg::CMD_DATA_RCVD: begin
                            n_peer_addr = i_item.src_id;
                            n_peer_seq  = i_item.frame_seq;
                            n_flags[sawa_pkg::EV_DATA_RCVD] = 1'b1;
                        end
                        sawa_pkg::CMD_ACK_RCVD: begin
                            n_flags[sawa_pkg::EV_ACK_RCVD] = 1'b1;
                        end
                        sawa_pkg::CMD_TX_CONFIRM: begin
                            if (r_last_ack) begin
                                n_flags[sawa_pkg::EV_ACK_TXD] = 1'b1;
                            end else begin
                                n_flags[sawa_pkg::EV_DATA_TXD] = 1'b1;
                            end
                        end
                        sawa_pkg::CMD_TIMEOUT: begin
                            n_timer = 1'b0;
                            n_flags[sawa_pkg::EV_TIMEOUT] = 1'b1;
                        end
                        sawa_pkg::CMD_NEW_DATA: begin
                            n_flags[sawa_pkg::EV_DATA_SEND] = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sawa_pkg::ENG_RUN: begin
                if (!r_have_held || out_free) begin
                    if (r_have_held) begin
                        n_out_valid = 1'b1;
                        n_out       = r_held;
                        n_out.last  = !p_take;
                    end
                    if (p_take) begin
                        n_fsm       = p_fsm;
                        n_flags     = p_flags;
                        n_next_seq  = p_next_seq;
                        n_out_seq   = p_out_seq;
                        n_retry     = p_retry;
                        n_timer     = p_timer;
                        n_last_ack  = p_last_ack;
                        n_held      = p_res;
                        n_have_held = 1'b1;
                    end else begin
                        n_fsm       = p_fsm;
                        n_have_held = 1'b0;
                        n_eng       = sawa_pkg::ENG_IDLE;
                    end
                end
            end
            default: begin
                n_eng = sawa_pkg::ENG_IDLE;
            end
        endcase
    end

    // control and protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng       <= sawa_pkg::ENG_IDLE;
            r_fsm       <= sawa_pkg::ST_IDLE;
            r_flags     <= '0;
            r_next_seq  <= '0;
            r_out_seq   <= '0;
            r_retry     <= '0;
            r_timer     <= 1'b0;
            r_last_ack  <= 1'b0;
            r_peer_addr <= '0;
            r_peer_seq  <= '0;
            r_have_held <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_eng       <= n_eng;
            r_fsm       <= n_fsm;
            r_flags     <= n_flags;
            r_next_seq  <= n_next_seq;
            r_out_seq   <= n_out_seq;
            r_retry     <= n_retry;
            r_timer     <= n_timer;
            r_last_ack  <= n_last_ack;
            r_peer_addr <= n_peer_addr;
            r_peer_seq  <= n_peer_seq;
            r_have_held <= n_have_held;
            r_out_valid <= n_out_valid;
        end
    end

    // held and output payload
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_out  <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/core/stop_and_wait_arq_fsm_core.sv =====
`timescale 1ns / 1ps

// Stop-and-wait ARQ control core.
// Input channel (i_valid / o_ready): one event per transaction, command with the
// sender address and sequence number of a received data frame. Unknown commands
// are accepted and have no effect.
// Output channel (o_valid / i_ready): zero to six result transactions per event,
// in order; o_last marks the final result of an event.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 destination id, 1 retry limit) in the same cycle. The user must write only
// while the core is idle; the core itself does not enforce it. The first result of an
// event passes through the event queue, the engine's event latch, the held result
// and the output register. The engine latches the event, runs one protocol pass
// per result and then a pass that finds nothing left; this loop sets the throughput.
// A small event queue in front of the engine keeps taking events while it works.
// Reset (synchronous, active low) clears the protocol state, the queue and the
// output register and loads the register defaults.
// When the receiver stalls, the current result holds and the engine pauses after
// computing the next one; the event queue keeps accepting until it is full.
module stop_and_wait_arq_fsm_core #(
    parameter int QUEUE_DEPTH = sawa_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_command,
    input  logic [7:0] i_src_id,
    input  logic [7:0] i_frame_seq,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_action,
    output logic [7:0] o_tx_seq,
    output logic [7:0] o_tx_dest,
    output logic       o_start_timer,
    output logic       o_stop_timer,
    output logic [1:0] o_machine_state,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    sawa_pkg::t_cfg    r_cfg, n_cfg;
    sawa_pkg::t_item   in_item;
    sawa_pkg::t_item   q_item;
    sawa_pkg::t_result result;
    logic              q_valid;
    logic              q_ready;

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                sawa_pkg::CFG_DEST_ID:  n_cfg.dest_id  = i_cfg_data;
                sawa_pkg::CFG_MAX_RETX: n_cfg.max_retx = i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_id  <= sawa_pkg::DEST_ID_RST;
            r_cfg.max_retx <= sawa_pkg::MAX_RETX_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign in_item.command   = i_command;
    assign in_item.src_id    = i_src_id;
    assign in_item.frame_seq = i_frame_seq;

    // event queue
    sawa_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    // protocol engine and output register
    sawa_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_item   (q_item),
        .i_cfg    (r_cfg),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_action        = result.action;
    assign o_tx_seq        = result.tx_seq;
    assign o_tx_dest       = result.tx_dest;
    assign o_start_timer   = result.start_timer;
    assign o_stop_timer    = result.stop_timer;
    assign o_machine_state = result.machine_state;
    assign o_last          = result.last;

endmodule

// ===== rtl/core/sawa_checker.sv =====
`timescale 1ns / 1ps

`include "stop_and_wait_arq_fsm_core_assert.svh"

module sawa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [2:0] o_action,
    input logic [7:0] o_tx_seq,
    input logic [7:0] o_tx_dest,
    input logic       o_start_timer,
    input logic       o_stop_timer,
    input logic [1:0] o_machine_state,
    input logic       o_last
);

    logic [23:0] out_payload;
    logic        is_send;
    logic        no_send_ok;
    logic        start_ok;
    logic        stop_ok;

    assign out_payload = {o_action, o_tx_seq, o_tx_dest, o_start_timer, o_stop_timer,
                          o_machine_state, o_last};
    assign is_send = (o_action == sawa_pkg::ACT_SEND_DATA) ||
                     (o_action == sawa_pkg::ACT_SEND_ACK);
    assign no_send_ok = (o_tx_seq == 8'd0) && (o_tx_dest == 8'd0);
    assign start_ok   = (o_action == sawa_pkg::ACT_NONE) &&
                        (o_machine_state == sawa_pkg::ST_WAIT) && !o_stop_timer;
    assign stop_ok    = (o_action == sawa_pkg::ACT_ACK_OK) &&
                        (o_machine_state == sawa_pkg::ST_IDLE);

    // stalled result keeps its payload
    `SAWA_ASSERT_HOLD(a_out_hold, i_clk, i_rst_n, o_valid, i_ready, out_payload)

    // only send results carry a frame sequence and destination
    `SAWA_ASSERT_IMPL(a_no_send_fields, i_clk, i_rst_n, o_valid && !is_send, no_send_ok)

    // timer start only comes with a silent move to waiting
    `SAWA_ASSERT_IMPL(a_start_timer, i_clk, i_rst_n, o_valid && o_start_timer, start_ok)

    // timer stop only with an accepted ack, ending back in idle
    `SAWA_ASSERT_IMPL(a_stop_timer, i_clk, i_rst_n, o_valid && o_stop_timer, stop_ok)

endmodule

bind stop_and_wait_arq_fsm_core sawa_checker u_sawa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_action        (o_action),
    .o_tx_seq        (o_tx_seq),
    .o_tx_dest       (o_tx_dest),
    .o_start_timer   (o_start_timer),
    .o_stop_timer    (o_stop_timer),
    .o_machine_state (o_machine_state),
    .o_last          (o_last)
);

// ===== verif/arq_result_checker.sv =====
`timescale 1ns / 1ps

module arq_result_checker
    import sawa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       o_ready,
    input  logic [2:0] i_command,
    input  logic [7:0] i_src_id,
    input  logic [7:0] i_frame_seq,
    input  logic       o_valid,
    input  logic       i_ready,
    input  logic [2:0] o_action,
    input  logic [7:0] o_tx_seq,
    input  logic [7:0] o_tx_dest,
    input  logic       o_start_timer,
    input  logic       o_stop_timer,
    input  logic [1:0] o_machine_state,
    input  logic       o_last,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         mismatch_count,
    output int         results_waiting,
    output int         results_checked
);

    // predicted protocol state
    t_fsm_state arq_state;
    logic [NUM_EVENTS-1:0] pend_flags;
    logic [7:0] next_seq;
    logic [7:0] out_seq;
    logic [3:0] retries;
    logic       timer_on;
    logic       last_was_ack;
    logic [7:0] peer_addr;
    logic [7:0] peer_seq;

    // predicted register contents
    logic [7:0] cfg_dest;
    logic [3:0] cfg_retx;

    t_result expected_results[$];

    // one machine pass; returns 1 when a pending flag was consumed
    function automatic bit run_arq_pass(output t_result r);
        int ev;
        r = '0;
        r.action = ACT_NONE;
        case (arq_state)
            ST_IDLE: begin
                // idle priority follows the flag numbering
                for (ev = 0; ev < NUM_EVENTS; ev++) begin
                    if (pend_flags[ev]) begin
                        pend_flags[ev] = 1'b0;
                        if (ev == EV_DATA_SEND) begin
                            out_seq      = next_seq;
                            next_seq     = next_seq + 8'd1;
                            retries      = '0;
                            last_was_ack = 1'b0;
                            arq_state    = ST_TX;
                            r.action     = ACT_SEND_DATA;
                            r.tx_seq     = out_seq;
                            r.tx_dest    = cfg_dest;
                        end else begin
                            r.action = ACT_DISCARD;
                        end
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            ST_TX: begin
                if (pend_flags[EV_DATA_TXD]) begin
                    pend_flags[EV_DATA_TXD] = 1'b0;
                    timer_on      = 1'b1;
                    arq_state     = ST_WAIT;
                    r.start_timer = 1'b1;
                    return 1'b1;
                end
                if (pend_flags[EV_ACK_TXD]) begin
                    pend_flags[EV_ACK_TXD] = 1'b0;
                    arq_state = (timer_on || pend_flags[EV_TIMEOUT]) ? ST_WAIT : ST_IDLE;
                    return 1'b1;
                end
                return 1'b0;
            end
            ST_WAIT: begin
                if (pend_flags[EV_ACK_RCVD]) begin
                    pend_flags[EV_ACK_RCVD] = 1'b0;
                    timer_on     = 1'b0;
                    arq_state    = ST_IDLE;
                    r.action     = ACT_ACK_OK;
                    r.stop_timer = 1'b1;
                    return 1'b1;
                end
                if (pend_flags[EV_TIMEOUT]) begin
                    pend_flags[EV_TIMEOUT] = 1'b0;
                    if (retries < cfg_retx) begin
                        retries      = retries + 4'd1;
                        last_was_ack = 1'b0;
                        arq_state    = ST_TX;
                        r.action     = ACT_SEND_DATA;
                        r.tx_seq     = out_seq;
                        r.tx_dest    = cfg_dest;
                    end else begin
                        arq_state = ST_IDLE;
                        r.action  = ACT_GIVE_UP;
                    end
                    return 1'b1;
                end
                if (pend_flags[EV_DATA_RCVD]) begin
                    pend_flags[EV_DATA_RCVD] = 1'b0;
                    last_was_ack = 1'b1;
                    arq_state    = ST_TX;
                    r.action     = ACT_SEND_ACK;
                    r.tx_seq     = peer_seq;
                    r.tx_dest    = peer_addr;
                    return 1'b1;
                end
                // leftover confirms and new data are dropped while waiting
                if (pend_flags[EV_DATA_TXD]) begin
                    pend_flags[EV_DATA_TXD] = 1'b0;
                    r.action = ACT_DISCARD;
                    return 1'b1;
                end
                if (pend_flags[EV_ACK_TXD]) begin
                    pend_flags[EV_ACK_TXD] = 1'b0;
                    r.action = ACT_DISCARD;
                    return 1'b1;
                end
                if (pend_flags[EV_DATA_SEND]) begin
                    pend_flags[EV_DATA_SEND] = 1'b0;
                    r.action = ACT_DISCARD;
                    return 1'b1;
                end
                return 1'b0;
            end
            default: begin
                arq_state = ST_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    // latch one event and queue every result it causes
    function automatic void predict_event(logic [2:0] cmd, logic [7:0] src, logic [7:0] fseq);
        t_result r;
        t_result held;
        bit      have_held;
        int      pass;
        have_held = 1'b0;
        case (cmd)
            CMD_DATA_RCVD: begin
                peer_addr = src;
                peer_seq  = fseq;
                pend_flags[EV_DATA_RCVD] = 1'b1;
            end
            CMD_ACK_RCVD:   pend_flags[EV_ACK_RCVD] = 1'b1;
            CMD_TX_CONFIRM: begin
                if (last_was_ack)
                    pend_flags[EV_ACK_TXD] = 1'b1;
                else
                    pend_flags[EV_DATA_TXD] = 1'b1;
            end
            CMD_TIMEOUT: begin
                timer_on = 1'b0;
                pend_flags[EV_TIMEOUT] = 1'b1;
            end
            CMD_NEW_DATA:   pend_flags[EV_DATA_SEND] = 1'b1;
            default: ;
        endcase
        for (pass = 0; pass < 8; pass++) begin
            if (!run_arq_pass(r))
                break;
            r.machine_state = arq_state;
            r.last          = 1'b0;
            if (have_held)
                expected_results.push_back(held);
            held      = r;
            have_held = 1'b1;
        end
        if (have_held) begin
            held.last = 1'b1;
            expected_results.push_back(held);
        end
    endfunction

    function automatic void check_field(string fname, int expv, int gotv);
        if (expv != gotv) begin
            $error("%s: expected %0d, got %0d", fname, expv, gotv);
            mismatch_count++;
        end
    endfunction

    // reset, register writes, result compare, then event prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            arq_state    = ST_IDLE;
            pend_flags   = '0;
            next_seq     = '0;
            out_seq      = '0;
            retries      = '0;
            timer_on     = 1'b0;
            last_was_ack = 1'b0;
            peer_addr    = '0;
            peer_seq     = '0;
            cfg_dest     = DEST_ID_RST;
            cfg_retx     = MAX_RETX_RST;
            mismatch_count  = 0;
            results_checked = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_DEST_ID)
                    cfg_dest = i_cfg_data;
                else
                    cfg_retx = i_cfg_data[3:0];
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation: action %0d", o_action);
                    mismatch_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("action", exp_r.action, o_action);
                    check_field("tx_seq", exp_r.tx_seq, o_tx_seq);
                    check_field("tx_dest", exp_r.tx_dest, o_tx_dest);
                    check_field("start_timer", exp_r.start_timer, o_start_timer);
                    check_field("stop_timer", exp_r.stop_timer, o_stop_timer);
                    check_field("machine_state", exp_r.machine_state, o_machine_state);
                    check_field("last", exp_r.last, o_last);
                    results_checked++;
                end
            end
            if (i_valid && o_ready)
                predict_event(i_command, i_src_id, i_frame_seq);
        end
        results_waiting = expected_results.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sawa_pkg::*;

    localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNKNOWN_LAST  = 3'd7;
    localparam int SETTLE_CYCLES   = 16;
    localparam int EVENTS_PER_PHASE = 75;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_PATTERN
    } t_rx_mode;

    logic       i_clk;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [2:0] i_command   = CMD_DATA_RCVD;
    logic [7:0] i_src_id    = '0;
    logic [7:0] i_frame_seq = '0;
    logic       i_ready     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic       i_cfg_index = CFG_DEST_ID;
    logic [7:0] i_cfg_data  = '0;

    logic       o_ready;
    logic       o_valid;
    logic [2:0] o_action;
    logic [7:0] o_tx_seq;
    logic [7:0] o_tx_dest;
    logic       o_start_timer;
    logic       o_stop_timer;
    logic [1:0] o_machine_state;
    logic       o_last;

    int mismatch_count;
    int results_waiting;
    int results_checked;

    int events_sent    = 0;
    int directed_count = 0;
    int setting_count  = 1;
    int burst_left     = 0;
    bit sender_steady  = 1'b0;

    stop_and_wait_arq_fsm_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_src_id       (i_src_id),
        .i_frame_seq    (i_frame_seq),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_action       (o_action),
        .o_tx_seq       (o_tx_seq),
        .o_tx_dest      (o_tx_dest),
        .o_start_timer  (o_start_timer),
        .o_stop_timer   (o_stop_timer),
        .o_machine_state(o_machine_state),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    arq_result_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_src_id       (i_src_id),
        .i_frame_seq    (i_frame_seq),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_action       (o_action),
        .o_tx_seq       (o_tx_seq),
        .o_tx_dest      (o_tx_dest),
        .o_start_timer  (o_start_timer),
        .o_stop_timer   (o_stop_timer),
        .o_machine_state(o_machine_state),
        .o_last         (o_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .mismatch_count (mismatch_count),
        .results_waiting(results_waiting),
        .results_checked(results_checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("FAIL stop_and_wait_arq_fsm_core");
        $finish;
    end

    // receiver back-pressure: always ready, coin flips, or a fixed stall pattern
    t_rx_mode rx_mode  = RX_ALWAYS;
    int       rx_left  = 0;
    int       rx_phase = 0;
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(RX_ALWAYS, RX_PATTERN));
            rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        rx_phase = (rx_phase + 1) % 7;
        case (rx_mode)
            RX_ALWAYS: i_ready <= 1'b1;
            RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
            default:   i_ready <= (rx_phase >= 3);
        endcase
    end

    // one event transaction; returns at the edge that accepts it
    task automatic send_event(input logic [2:0] cmd, input logic [7:0] src,
                              input logic [7:0] fseq);
        if (!sender_steady && burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_src_id    <= src;
        i_frame_seq <= fseq;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        if (cmd <= CMD_NEW_DATA)
            events_sent++;
    endtask

    task automatic send_cmd(input logic [2:0] cmd);
        send_event(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // hold off the sender until every expected result is out and the engine settles
    task automatic drain;
        i_valid <= 1'b0;
        do @(negedge i_clk); while (results_waiting != 0);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] dest, input logic [3:0] retx);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEST_ID;
        i_cfg_data  <= dest;
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_RETX;
        i_cfg_data  <= {4'b0, retx};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        setting_count++;
    endtask

    // new frame, confirm, maybe an ack for a peer frame, then the ack
    task automatic clean_exchange;
        send_cmd(CMD_NEW_DATA);
        send_cmd(CMD_TX_CONFIRM);
        if ($urandom_range(0, 1)) begin
            send_cmd(CMD_DATA_RCVD);
            send_cmd(CMD_TX_CONFIRM);
        end
        send_cmd(CMD_ACK_RCVD);
    endtask

    // new frame with a run of timeouts; may end in a give-up
    task automatic retry_exchange;
        int n;
        n = $urandom_range(0, 16);
        send_cmd(CMD_NEW_DATA);
        send_cmd(CMD_TX_CONFIRM);
        repeat (n) begin
            send_cmd(CMD_TIMEOUT);
            send_cmd(CMD_TX_CONFIRM);
        end
        if ($urandom_range(0, 1))
            send_cmd(CMD_ACK_RCVD);
    endtask

    task automatic noise_burst;
        repeat ($urandom_range(1, 4))
            send_cmd(3'($urandom_range(CMD_DATA_RCVD, CMD_UNKNOWN_LAST)));
    endtask

    task automatic random_phase(input int count);
        int target;
        int pick;
        target = events_sent + count;
        while (events_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
                clean_exchange();
            else if (pick < 8)
                retry_exchange();
            else
                noise_burst();
        end
    endtask

    // stimulus and verdict
    initial begin
        logic [2:0] c;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // events while idle: confirm before any transmission, timeout, data, ack
        send_event(CMD_TX_CONFIRM, 8'd0, 8'd0);
        send_event(CMD_TIMEOUT, 8'd0, 8'd0);
        send_event(CMD_DATA_RCVD, 8'hff, 8'hff);
        send_event(CMD_ACK_RCVD, 8'd0, 8'd0);
        // unknown commands latch nothing
        for (c = CMD_UNKNOWN_FIRST; c != CMD_DATA_RCVD; c++)
            send_event(c, 8'h5a, 8'ha5);
        // acks and peer data pile up while transmitting, repeats collapse
        send_event(CMD_NEW_DATA, 8'd0, 8'd0);
        send_event(CMD_ACK_RCVD, 8'd0, 8'd0);
        send_event(CMD_ACK_RCVD, 8'd0, 8'd0);
        send_event(CMD_DATA_RCVD, 8'd0, 8'd0);
        send_event(CMD_DATA_RCVD, 8'hff, 8'h80);
        send_event(CMD_TX_CONFIRM, 8'd0, 8'd0);
        // retries up to the default limit, then give up
        send_event(CMD_NEW_DATA, 8'd0, 8'd0);
        send_event(CMD_TX_CONFIRM, 8'd0, 8'd0);
        repeat (3) begin
            send_event(CMD_TIMEOUT, 8'd0, 8'd0);
            send_event(CMD_TX_CONFIRM, 8'd0, 8'd0);
        end
        send_event(CMD_TIMEOUT, 8'd0, 8'd0);
        // peer frame acked while waiting
        send_event(CMD_NEW_DATA, 8'd0, 8'd0);
        send_event(CMD_TX_CONFIRM, 8'd0, 8'd0);
        send_event(CMD_DATA_RCVD, 8'ha5, 8'h3c);
        send_event(CMD_TX_CONFIRM, 8'd0, 8'd0);
        send_event(CMD_ACK_RCVD, 8'd0, 8'd0);
        directed_count = events_sent;
        drain();

        // register extremes, then random settings
        write_config(8'd0, 4'd0);
        random_phase(EVENTS_PER_PHASE);
        drain();
        write_config(8'hff, 4'hf);
        sender_steady = 1'b1;
        random_phase(EVENTS_PER_PHASE);
        sender_steady = 1'b0;
        drain();
        write_config(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
        random_phase(EVENTS_PER_PHASE);
        drain();
        write_config(8'($urandom_range(0, 255)), 4'd1);
        random_phase(EVENTS_PER_PHASE);
        drain();

        $display("run covered %0d events (%0d directed) under %0d register settings",
                 events_sent, directed_count, setting_count);
        $display("%0d results compared, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS stop_and_wait_arq_fsm_core");
        else
            $display("FAIL stop_and_wait_arq_fsm_core");
        $finish;
    end

endmodule
